>>> rtl/core/ps2_mouse_packet_tracker_defines.svh
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker: assertion macros
// Shared concurrent-assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH

// Condition that must hold at every clock edge outside reset
`define PMT_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent
`define PMT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/pmt_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker: package
// Mode codes, command kinds, command record and fixed constants.
// ----------------------------------------------------------------------------
package pmt_pkg;

	// Input item kinds carried on s_tuser
	localparam logic [1:0] MODE_BYTE      = 2'd0;
	localparam logic [1:0] MODE_CLR_CHG   = 2'd1;
	localparam logic [1:0] MODE_CLR_LATCH = 2'd2;

	// Packet framing
	localparam int SYNC_BIT = 3;
	localparam logic [1:0] OVF_NONE = 2'b00;

	// Size register reset values
	localparam logic [12:0] DEF_WIDTH  = 13'd1024;
	localparam logic [12:0] DEF_HEIGHT = 13'd768;
	localparam int SIZE_BITS = 13;

	// Register addresses (byte addresses)
	localparam logic [2:0] ADDR_WIDTH  = 3'd0;
	localparam logic [2:0] ADDR_HEIGHT = 3'd4;

	// Command queue depth between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		CMD_REPORT    = 2'd0,
		CMD_CLR_CHG   = 2'd1,
		CMD_CLR_LATCH = 2'd2,
		CMD_PACKET    = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [2:0]  buttons;
		logic [7:0]  dx;
		logic [7:0]  dy;
	} cmd_t;

	// Push request from the front to the queue
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} push_t;

endpackage

>>> rtl/core/pmt_front.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker: front end
// Accepts input transactions, frames 3-byte packets and issues one command
// per transaction to the command queue.
// ----------------------------------------------------------------------------
module pmt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [1:0]    in_mode,
	input  logic [7:0]    in_byte,
	input  logic          q_full,
	output logic          in_ready,
	output pmt_pkg::push_t push
);

	typedef enum logic [2:0] {
		PH_SYNC = 3'b001,
		PH_DX   = 3'b010,
		PH_DY   = 3'b100
	} phase_t;

	phase_t      phase_q;
	logic [7:0]  first_q;
	logic [7:0]  dx_q;
	logic        accept;
	phase_t      phase_nxt;
	pmt_pkg::cmd_t cmd;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Classify the transaction and step the byte phase
	always_comb begin
		phase_nxt   = phase_q;
		cmd.kind    = pmt_pkg::CMD_REPORT;
		cmd.buttons = first_q[2:0];
		cmd.dx      = dx_q;
		cmd.dy      = in_byte;
		case (in_mode)
			pmt_pkg::MODE_CLR_CHG: begin
				cmd.kind = pmt_pkg::CMD_CLR_CHG;
			end
			pmt_pkg::MODE_CLR_LATCH: begin
				cmd.kind = pmt_pkg::CMD_CLR_LATCH;
			end
			pmt_pkg::MODE_BYTE: begin
				case (phase_q)
					PH_SYNC: begin
						if (in_byte[pmt_pkg::SYNC_BIT])
							phase_nxt = PH_DX;
					end
					PH_DX: begin
						phase_nxt = PH_DY;
					end
					PH_DY: begin
						phase_nxt = PH_SYNC;
						// drop packets with either overflow bit set
						if (first_q[7:6] == pmt_pkg::OVF_NONE)
							cmd.kind = pmt_pkg::CMD_PACKET;
					end
					default: begin
						phase_nxt = PH_SYNC;
					end
				endcase
			end
			default: begin
				cmd.kind = pmt_pkg::CMD_REPORT;
			end
		endcase
	end

	assign push.valid = accept;
	assign push.cmd   = cmd;

	// Hold packet bytes and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC;
			first_q <= 8'd0;
			dx_q    <= 8'd0;
		end else if (accept && in_mode == pmt_pkg::MODE_BYTE) begin
			phase_q <= phase_nxt;
			if (phase_q == PH_SYNC && in_byte[pmt_pkg::SYNC_BIT])
				first_q <= in_byte;
			if (phase_q == PH_DX)
				dx_q <= in_byte;
		end
	end

endmodule

>>> rtl/core/pmt_queue.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker: command queue
// Two-entry first-in first-out buffer between the front and the back end.
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_tracker_defines.svh"

module pmt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  pmt_pkg::push_t push,
	input  logic           pop,
	output logic           full,
	output logic           valid,
	output pmt_pkg::cmd_t  head
);

	localparam int PW = $clog2(pmt_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(pmt_pkg::QUEUE_DEPTH + 1);

	pmt_pkg::cmd_t entry_q [pmt_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(pmt_pkg::QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign head    = entry_q[rd_ptr_q];
	assign do_push = push.valid && !full;
	assign do_pop  = pop && valid;

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push.cmd;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

	`PMT_ASSERT_ALWAYS(a_no_overfill, count_q <= CW'(pmt_pkg::QUEUE_DEPTH), "queue overfilled")
	`PMT_ASSERT_ALWAYS(a_no_push_full, !(push.valid && full), "push into full queue")
	`PMT_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_q == $past(count_q) + CW'(1), "count did not rise")

endmodule

>>> rtl/core/pmt_back.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker: back end
// Executes queued commands on the cursor, button and flag state, and holds
// the result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_tracker_defines.svh"

module pmt_back #(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  pmt_pkg::cmd_t         q_head,
	output logic                  q_pop,
	input  logic [COORD_BITS-1:0] lim_x,
	input  logic [COORD_BITS-1:0] lim_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] pos_x,
	output logic [COORD_BITS-1:0] pos_y,
	output logic [2:0]            buttons,
	output logic [2:0]            latch,
	output logic                  changed,
	output logic                  done
);

	localparam int VW = COORD_BITS + 2;

	logic [COORD_BITS-1:0] pos_x_q;
	logic [COORD_BITS-1:0] pos_y_q;
	logic [2:0]            btn_q;
	logic [2:0]            latch_q;
	logic                  chg_q;
	logic                  done_q;
	logic                  valid_q;
	logic signed [VW-1:0]  vx;
	logic signed [VW-1:0]  vy;
	logic [COORD_BITS-1:0] nx;
	logic [COORD_BITS-1:0] ny;
	logic                  moved;
	logic                  take_pkt;
	logic                  stall;

	// Take a command when the result slot is free or being emptied
	assign q_pop    = q_valid && (!valid_q || out_ready);
	assign take_pkt = q_pop && (q_head.kind == pmt_pkg::CMD_PACKET);
	assign stall    = valid_q && !out_ready;

	// Move and clamp both coordinates
	always_comb begin
		vx = $signed({2'b00, pos_x_q}) + $signed({{(VW-8){q_head.dx[7]}}, q_head.dx});
		vy = $signed({2'b00, pos_y_q}) - $signed({{(VW-8){q_head.dy[7]}}, q_head.dy});
		if (vx[VW-1])
			nx = '0;
		else if (vx[VW-2:0] > {1'b0, lim_x})
			nx = lim_x;
		else
			nx = vx[COORD_BITS-1:0];
		if (vy[VW-1])
			ny = '0;
		else if (vy[VW-2:0] > {1'b0, lim_y})
			ny = lim_y;
		else
			ny = vy[COORD_BITS-1:0];
		moved = (q_head.dx != 8'd0) || (q_head.dy != 8'd0) || (q_head.buttons != btn_q);
	end

	// Update state and load the result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= COORD_BITS'(pmt_pkg::DEF_WIDTH / 2);
			pos_y_q <= COORD_BITS'(pmt_pkg::DEF_HEIGHT / 2);
			btn_q   <= 3'd0;
			latch_q <= 3'd0;
			chg_q   <= 1'b0;
			done_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_q <= 1'b1;
				done_q  <= take_pkt;
				case (q_head.kind)
					pmt_pkg::CMD_CLR_CHG: begin
						chg_q <= 1'b0;
					end
					pmt_pkg::CMD_CLR_LATCH: begin
						latch_q <= 3'd0;
					end
					pmt_pkg::CMD_PACKET: begin
						pos_x_q <= nx;
						pos_y_q <= ny;
						latch_q <= latch_q | (q_head.buttons & ~btn_q);
						btn_q   <= q_head.buttons;
						if (moved)
							chg_q <= 1'b1;
					end
					default: ;
				endcase
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign buttons   = btn_q;
	assign latch     = latch_q;
	assign changed   = chg_q;
	assign done      = done_q;

	`PMT_ASSERT_NEXT(a_stall_holds, stall, $stable({pos_x_q, done_q, latch_q}), "state moved in stall")
	`PMT_ASSERT_ALWAYS(a_x_bound, !take_pkt || nx <= lim_x, "x beyond limit")

endmodule

>>> rtl/core/ps2_mouse_packet_tracker.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker: top level
// Assembles PS/2 mouse bytes into packets and tracks a clamped cursor.
// ----------------------------------------------------------------------------
// Input channel s_*: s_tuser carries the item kind (received byte, clear the
// changed flag, clear the press latch), s_tdata the mouse byte. Every input
// transaction yields exactly one result transaction on m_*, carrying cursor
// position, buttons, press latch, changed flag and a packet-done bit.
// An input transaction passes through the command queue and then the result
// register before it shows on m_tvalid. Throughput is one item per cycle
// while m_tready stays high.
// When m_tready is low the result register holds and the two-entry command
// queue fills; s_tready drops once it is full and rises as soon as the
// receiver takes a result.
// Reset puts the cursor at 512,384, clears buttons, latch, flag and packet
// framing, and loads the size registers with 1024 and 768. APB writes screen
// width at address 0 and height at 4; the user must write only while idle (not enforced).
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker #(
	parameter int COORD_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_tuser,   // [1:0] mode
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// from bit 0: cursor_x, cursor_y, button_state, press_latch,
	// changed_flag, packet_done, zero fill
	output logic [((2*COORD_BITS+8+7)/8)*8-1:0] m_tdata
);

	localparam int TDATA_W = ((2 * COORD_BITS + 8 + 7) / 8) * 8;
	localparam int RES_W   = 2 * COORD_BITS + 8;

	logic [pmt_pkg::SIZE_BITS-1:0] width_q;
	logic [pmt_pkg::SIZE_BITS-1:0] height_q;
	logic [COORD_BITS-1:0]         lim_x_q;
	logic [COORD_BITS-1:0]         lim_y_q;
	logic                          wr_en;

	pmt_pkg::push_t push;
	pmt_pkg::cmd_t  head;
	logic           q_full;
	logic           q_valid;
	logic           q_pop;

	logic [COORD_BITS-1:0] pos_x;
	logic [COORD_BITS-1:0] pos_y;
	logic [2:0]            buttons;
	logic [2:0]            latch;
	logic                  changed;
	logic                  done;

	// Largest coordinate for a given size
	function automatic logic [COORD_BITS-1:0] limit_of(input logic [pmt_pkg::SIZE_BITS-1:0] size);
		logic [31:0] m;
		logic [31:0] cmax;
		cmax = (32'd1 << COORD_BITS) - 32'd1;
		m    = (size == '0) ? 32'd0 : {19'd0, size} - 32'd1;
		if (m > cmax)
			m = cmax;
		return m[COORD_BITS-1:0];
	endfunction

	// Configuration registers
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= pmt_pkg::DEF_WIDTH;
			height_q <= pmt_pkg::DEF_HEIGHT;
			lim_x_q  <= limit_of(pmt_pkg::DEF_WIDTH);
			lim_y_q  <= limit_of(pmt_pkg::DEF_HEIGHT);
		end else if (wr_en) begin
			if (paddr[2] == pmt_pkg::ADDR_HEIGHT[2]) begin
				height_q <= pwdata[pmt_pkg::SIZE_BITS-1:0];
				lim_y_q  <= limit_of(pwdata[pmt_pkg::SIZE_BITS-1:0]);
			end else begin
				width_q <= pwdata[pmt_pkg::SIZE_BITS-1:0];
				lim_x_q <= limit_of(pwdata[pmt_pkg::SIZE_BITS-1:0]);
			end
		end
	end

	// Read back the size registers
	always_comb begin
		case (paddr)
			pmt_pkg::ADDR_WIDTH:  prdata = 32'(width_q);
			pmt_pkg::ADDR_HEIGHT: prdata = 32'(height_q);
			default:              prdata = 32'd0;
		endcase
	end

	pmt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_mode  (s_tuser),
		.in_byte  (s_tdata),
		.q_full   (q_full),
		.in_ready (s_tready),
		.push     (push)
	);

	pmt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (q_pop),
		.full   (q_full),
		.valid  (q_valid),
		.head   (head)
	);

	pmt_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (head),
		.q_pop     (q_pop),
		.lim_x     (lim_x_q),
		.lim_y     (lim_y_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.buttons   (buttons),
		.latch     (latch),
		.changed   (changed),
		.done      (done)
	);

	// Pack the result transaction
	logic [RES_W-1:0] res;
	assign res     = {done, changed, latch, buttons, pos_y, pos_x};
	assign m_tdata = TDATA_W'(res);

endmodule

>>> tb/tb_ps2_mouse_packet_tracker.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker: testbench
// Sends mouse byte streams and clear commands with random gaps and
// back-pressure, and checks every result transaction against a cycle-free
// packet and cursor predictor or a fixed directed report. Sizes are
// reprogrammed over APB between phases, the extremes included.
// ----------------------------------------------------------------------------
module tb_ps2_mouse_packet_tracker;

	localparam int COORD_BITS = 12;
	localparam int COORD_MAX = (1 << COORD_BITS) - 1;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int N_DIRECTED = 25;
	localparam int N_PHASES = 9;
	localparam int MAX_REPORTED = 10;

	// Result word, packet_done in the top bit, cursor_x at bit 0
	typedef struct packed {
		logic        packet_done;
		logic        changed_flag;
		logic [2:0]  press_latch;
		logic [2:0]  button_state;
		logic [11:0] cursor_y;
		logic [11:0] cursor_x;
	} report_t;

	typedef struct {
		logic [1:0] mode;
		logic [7:0] data;
		bit         typed;
		report_t    exp;
	} stim_row_t;

	localparam report_t AT_RESET = '{1'b0, 1'b0, 3'd0, 3'd0, 12'd384, 12'd512};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] rx_byte
	logic [1:0]  s_tuser;   // [1:0] mode
	logic        m_tvalid;
	logic        m_tready;
	// from bit 0: cursor_x, cursor_y, button_state, press_latch,
	// changed_flag, packet_done
	logic [31:0] m_tdata;

	// Predictor state and programmed sizes
	logic [1:0]  trk_phase;
	logic [7:0]  trk_first;
	logic [7:0]  trk_second;
	logic [11:0] trk_x;
	logic [11:0] trk_y;
	logic [2:0]  trk_buttons;
	logic [2:0]  trk_sticky;
	logic        trk_dirty;
	logic [12:0] trk_width;
	logic [12:0] trk_height;

	report_t pending_reports[$];

	int fail_count = 0;
	int items_sent = 0;
	int reports_checked = 0;
	int packets_kept = 0;
	int sizes_applied = 0;
	bit send_steady = 0;
	bit recv_steady = 0;
	int bias_x = 0;
	int bias_y = 0;

	// Directed rows: reset view, sync filter, extremes of the deltas, clears,
	// zero-motion packet and the discarded packets
	stim_row_t dir_rows [N_DIRECTED] = '{
		'{MODE_UNUSED,             8'hFF, 1'b1, AT_RESET},
		'{pmt_pkg::MODE_BYTE,      8'h00, 1'b1, AT_RESET},
		'{pmt_pkg::MODE_BYTE,      8'hF7, 1'b1, AT_RESET},
		'{pmt_pkg::MODE_CLR_CHG,   8'hFF, 1'b1, AT_RESET},
		'{pmt_pkg::MODE_BYTE,      8'h09, 1'b0, '0},
		'{pmt_pkg::MODE_BYTE,      8'h7F, 1'b0, '0},
		'{pmt_pkg::MODE_BYTE,      8'h80, 1'b0, '0},
		'{pmt_pkg::MODE_BYTE,      8'h0F, 1'b0, '0},
		'{pmt_pkg::MODE_BYTE,      8'h80, 1'b0, '0},
		'{pmt_pkg::MODE_BYTE,      8'h7F, 1'b0, '0},
		'{pmt_pkg::MODE_CLR_CHG,   8'h00, 1'b0, '0},
		'{pmt_pkg::MODE_CLR_LATCH, 8'h55, 1'b0, '0},
		'{pmt_pkg::MODE_BYTE,      8'h0F, 1'b0, '0},
		'{pmt_pkg::MODE_BYTE,      8'h00, 1'b0, '0},
		'{pmt_pkg::MODE_BYTE,      8'h00, 1'b0, '0},
		'{pmt_pkg::MODE_BYTE,      8'hC8, 1'b0, '0},
		'{pmt_pkg::MODE_BYTE,      8'h7F, 1'b0, '0},
		'{pmt_pkg::MODE_BYTE,      8'h7F, 1'b0, '0},
		'{pmt_pkg::MODE_BYTE,      8'h88, 1'b0, '0},
		'{pmt_pkg::MODE_CLR_LATCH, 8'hAA, 1'b0, '0},
		'{pmt_pkg::MODE_BYTE,      8'h05, 1'b0, '0},
		'{pmt_pkg::MODE_BYTE,      8'h05, 1'b0, '0},
		'{pmt_pkg::MODE_BYTE,      8'h48, 1'b0, '0},
		'{pmt_pkg::MODE_BYTE,      8'hFF, 1'b0, '0},
		'{pmt_pkg::MODE_BYTE,      8'hFF, 1'b0, '0}
	};

	// Phase plan: sizes and drift of the deltas (0 none, 1 positive, 2 negative);
	// a size of -1 is drawn at random, -2 drawn over the whole register range
	int ph_width  [N_PHASES] = '{1, 0, 4096, 8191, 2, 4096, -1, -2, 1024};
	int ph_height [N_PHASES] = '{1, 0, 4096, 8191, 3, 1,    -1, -2, 768};
	int ph_bias_x [N_PHASES] = '{0, 0, 1,    1,    2, 0,    -1, -1, 0};
	int ph_bias_y [N_PHASES] = '{0, 0, 2,    2,    1, 0,    -1, -1, 0};
	int ph_items  [N_PHASES] = '{50, 30, 90, 60, 50, 50, 60, 60, 50};

	ps2_mouse_packet_tracker #(
		.COORD_BITS(COORD_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Move a coordinate by a delta and clamp it to the screen size
	function automatic logic [11:0] clamp_coord(logic [11:0] pos, int delta, logic [12:0] size);
		int lim;
		int v;
		lim = (size == 0) ? 0 : int'(size) - 1;
		if (lim > COORD_MAX)
			lim = COORD_MAX;
		v = int'(pos) + delta;
		if (v < 0)
			return 12'd0;
		if (v > lim)
			return lim[11:0];
		return v[11:0];
	endfunction

	// Advance the packet framing and cursor by one input item
	function automatic report_t track_byte(logic [1:0] mode, logic [7:0] b);
		report_t r;
		logic [2:0] nb;
		int dx;
		int dy;
		logic done;
		done = 1'b0;
		case (mode)
			pmt_pkg::MODE_CLR_CHG: trk_dirty = 1'b0;
			pmt_pkg::MODE_CLR_LATCH: trk_sticky = 3'd0;
			pmt_pkg::MODE_BYTE: begin
				if (trk_phase == 2'd0) begin
					if (b[pmt_pkg::SYNC_BIT]) begin
						trk_first = b;
						trk_phase = 2'd1;
					end
				end else if (trk_phase == 2'd1) begin
					trk_second = b;
					trk_phase = 2'd2;
				end else begin
					trk_phase = 2'd0;
					if (trk_first[7:6] == pmt_pkg::OVF_NONE) begin
						dx = int'($signed(trk_second));
						dy = int'($signed(b));
						nb = trk_first[2:0];
						trk_x = clamp_coord(trk_x, dx, trk_width);
						trk_y = clamp_coord(trk_y, -dy, trk_height);
						trk_sticky = trk_sticky | (nb & ~trk_buttons);
						if (nb != trk_buttons || dx != 0 || dy != 0)
							trk_dirty = 1'b1;
						trk_buttons = nb;
						done = 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.cursor_x = trk_x;
		r.cursor_y = trk_y;
		r.button_state = trk_buttons;
		r.press_latch = trk_sticky;
		r.changed_flag = trk_dirty;
		r.packet_done = done;
		return r;
	endfunction

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTED)
			$display("mismatch: %s", msg);
	endtask

	// Offer one item after a random gap and log its expected report on acceptance
	task automatic send_item(logic [1:0] mode, logic [7:0] data, bit typed = 0,
			report_t typed_exp = '0);
		int gap;
		report_t r;
		gap = send_steady ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= mode;
		do @(posedge clk); while (!s_tready);
		r = track_byte(mode, data);
		pending_reports.push_back(typed ? typed_exp : r);
		items_sent++;
	endtask

	// Write a size register, then read it back
	task automatic write_size(logic [2:0] addr, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {19'd0, value[12:0]})
			note_failure($sformatf("register %0d read %h, expected %h", addr, prdata,
				{19'd0, value[12:0]}));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == pmt_pkg::ADDR_WIDTH)
			trk_width = value[12:0];
		else
			trk_height = value[12:0];
		sizes_applied++;
	endtask

	function automatic logic [7:0] draw_delta(int bias);
		if ($urandom_range(0, 7) == 0)
			return 8'h00;
		case (bias)
			1: return 8'($urandom_range(8'h60, 8'h7F));
			2: return 8'($urandom_range(8'h80, 8'hA0));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly well-formed packets, with noise, clears and broken packets mixed in
	task automatic send_random(int n);
		int count;
		int pick;
		logic [1:0] ovf;
		logic [7:0] head;
		count = 0;
		while (count < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				ovf = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3)) :
					pmt_pkg::OVF_NONE;
				head = {ovf, 2'($urandom_range(0, 3)), 1'b1, 3'($urandom_range(0, 7))};
				send_item(pmt_pkg::MODE_BYTE, head);
				if ($urandom_range(0, 9) == 0)
					send_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
				send_item(pmt_pkg::MODE_BYTE, draw_delta(bias_x));
				send_item(pmt_pkg::MODE_BYTE, draw_delta(bias_y));
				count += 3;
			end else if (pick < 75) begin
				send_item(pmt_pkg::MODE_BYTE,
					{4'($urandom_range(0, 15)), 1'b1, 3'($urandom_range(0, 7))});
				send_item(pmt_pkg::MODE_BYTE, 8'($urandom_range(0, 255)));
				count += 2;
			end else if (pick < 85) begin
				send_item(pmt_pkg::MODE_BYTE, 8'($urandom_range(0, 255)));
				count++;
			end else begin
				send_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
				count++;
			end
		end
	endtask

	// Receiver: stall at random, then check each result transaction
	initial begin
		int gap;
		report_t got;
		report_t exp;
		@(posedge arst_n);
		forever begin
			gap = recv_steady ? 0 : $urandom_range(0, 9);
			@(negedge clk);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = m_tdata;
			if (pending_reports.size() == 0) begin
				note_failure($sformatf("unexpected result %h", got));
			end else begin
				exp = pending_reports.pop_front();
				reports_checked++;
				if (got.packet_done)
					packets_kept++;
				if (got !== exp)
					note_failure($sformatf(
						"x %0d/%0d y %0d/%0d btn %0d/%0d latch %0d/%0d chg %0d/%0d done %0d/%0d",
						got.cursor_x, exp.cursor_x, got.cursor_y, exp.cursor_y,
						got.button_state, exp.button_state, got.press_latch, exp.press_latch,
						got.changed_flag, exp.changed_flag, got.packet_done, exp.packet_done));
			end
		end
	end

	// Stimulus: reset, directed rows, then phases of random items
	initial begin
		int w;
		int h;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = pmt_pkg::MODE_BYTE;
		m_tready = 1'b0;
		trk_phase = 2'd0;
		trk_first = 8'd0;
		trk_second = 8'd0;
		trk_x = 12'(pmt_pkg::DEF_WIDTH / 2);
		trk_y = 12'(pmt_pkg::DEF_HEIGHT / 2);
		trk_buttons = 3'd0;
		trk_sticky = 3'd0;
		trk_dirty = 1'b0;
		trk_width = pmt_pkg::DEF_WIDTH;
		trk_height = pmt_pkg::DEF_HEIGHT;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			send_item(dir_rows[i].mode, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].exp);

		for (int p = 0; p < N_PHASES; p++) begin
			// Idle the input and let the block drain before touching the size registers
			@(negedge clk);
			s_tvalid <= 1'b0;
			while (pending_reports.size() != 0) @(posedge clk);
			repeat (4) @(posedge clk);
			w = (ph_width[p] == -1) ? $urandom_range(1, 4096) :
				(ph_width[p] == -2) ? $urandom_range(0, 8191) : ph_width[p];
			h = (ph_height[p] == -1) ? $urandom_range(1, 4096) :
				(ph_height[p] == -2) ? $urandom_range(0, 8191) : ph_height[p];
			write_size(pmt_pkg::ADDR_WIDTH, {19'($urandom_range(0, 524287)), 13'(w)});
			write_size(pmt_pkg::ADDR_HEIGHT, {19'($urandom_range(0, 524287)), 13'(h)});
			bias_x = (ph_bias_x[p] < 0) ? $urandom_range(0, 2) : ph_bias_x[p];
			bias_y = (ph_bias_y[p] < 0) ? $urandom_range(0, 2) : ph_bias_y[p];
			send_steady = ($urandom_range(0, 3) == 0);
			recv_steady = ($urandom_range(0, 3) == 0);
			send_random(ph_items[p]);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (pending_reports.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("sent %0d items, checked %0d results, %0d kept packets",
			items_sent, reports_checked, packets_kept);
		$display("size writes %0d, failures %0d", sizes_applied, fail_count);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#400000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
